### sv/msbs_pkg.sv
// Shared types, constants and signature tables for the masked byte signature scanner.
package msbs_pkg;

  localparam int PATTERN_BYTES = 28;
  localparam int WIN_DEPTH     = PATTERN_BYTES - 1;
  localparam int SEEN_W        = 31;
  localparam int OFFSET_W      = 30;
  localparam int ADDR_W        = 48;

  localparam logic [SEEN_W-1:0] SEEN_MAX   = {SEEN_W{1'b1}};
  localparam logic [SEEN_W-1:0] PAT_LEN    = SEEN_W'(PATTERN_BYTES);
  // highest seen count whose candidate offset still fits in OFFSET_W bits
  localparam logic [SEEN_W-1:0] SEEN_LIMIT = SEEN_W'((64'd1 << OFFSET_W) - 64'd1 + 64'(PATTERN_BYTES));
  localparam logic [ADDR_W-1:0] INSN_LEN   = ADDR_W'(7);

  // signature bytes; positions with care cleared are wildcards
  localparam logic [7:0] SIG_VALUE [PATTERN_BYTES] = '{
    8'h48, 8'h89, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE8, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h33, 8'hD2, 8'h41, 8'hB8, 8'hF8, 8'h0A, 8'h00, 8'h00,
    8'h48, 8'h8B, 8'hC8, 8'h48, 8'h8B, 8'hD8, 8'hE8, 8'h00
  };
  localparam logic SIG_CARE [PATTERN_BYTES] = '{
    1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0
  };

  typedef struct packed {
    logic [ADDR_W-1:0]   target_address;
    logic [OFFSET_W-1:0] match_offset;
    logic                found;
  } msbs_result_t;

  // one byte position of the signature: wildcard or exact compare
  function automatic logic sig_hit(input int idx, input logic [7:0] b);
    sig_hit = !SIG_CARE[idx] || (b == SIG_VALUE[idx]);
  endfunction

endpackage

### sv/msbs_cell.sv
// One window cell: holds a byte, passes it to its lower neighbor, checks it against the signature.
module msbs_cell #(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  logic       shift_en,
  input  logic [7:0] din,
  output logic [7:0] dout,
  output logic       hit
);
  import msbs_pkg::*;

  logic [7:0] byte_q;

  // shift register stage
  always_ff @(posedge clk) begin
    if (shift_en) begin
      byte_q <= din;
    end
  end

  assign dout = byte_q;
  assign hit  = sig_hit(IDX, byte_q);

endmodule

### sv/msbs_out_queue.sv
// Two-entry output queue (output register plus skid) for scanner results.
module msbs_out_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  msbs_pkg::msbs_result_t push_data,
  output logic                   can_push,
  output logic                   out_valid,
  input  logic                   out_ready,
  output msbs_pkg::msbs_result_t out_data
);
  import msbs_pkg::*;

  msbs_result_t head;
  msbs_result_t skid;
  logic         head_valid;
  logic         skid_valid;
  logic         pop;

  assign pop      = head_valid && out_ready;
  assign can_push = !skid_valid;

  // control: the skid only fills while the head is held
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (head_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end else if (pop) begin
      head_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        head <= skid;
      end
    end else if (push) begin
      if (head_valid && !pop) begin
        skid <= push_data;
      end else begin
        head <= push_data;
      end
    end
  end

  assign out_valid = head_valid;
  assign out_data  = head;

endmodule

### sv/masked_byte_signature_scanner.sv
// Top level: masked 28-byte signature search over a code byte stream.
// Throughput: one byte per cycle; a request is taken in the cycle it arrives while
// the result queue has room. A result reaches m_* only through the result queue's
// registers. A row of 27 byte cells forms the window; the compare
// and the 48-bit target add sit between the window and the two-entry result queue.
// Reset (rst, synchronous) clears section_base, byte count, match flag and the queue.
module masked_byte_signature_scanner (
  input  logic        clk,
  input  logic        rst,
  // configuration: section_base
  input  logic        cfg_wr_en,
  input  logic [47:0] cfg_wr_data,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] code_byte
  input  logic        s_tlast,
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata    // [0] found, [30:1] match_offset, [78:31] target_address
);
  import msbs_pkg::*;

  logic [ADDR_W-1:0] section_base;
  logic [SEEN_W-1:0] bytes_seen;
  logic              match_done;

  logic                accept;
  logic                shift_en;
  logic [7:0]          win [WIN_DEPTH];
  logic [7:0]          chain_in [WIN_DEPTH];
  logic [PATTERN_BYTES-1:0] hits;
  logic [SEEN_W-1:0]   seen_now;
  logic                in_range;
  logic                hit;
  logic                emit;
  logic [OFFSET_W-1:0] offset;
  logic [31:0]         disp;
  logic [ADDR_W-1:0]   target;
  msbs_result_t        result;
  msbs_result_t        out_res;
  logic                can_push;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = can_push;
  assign shift_en = accept && !s_tlast;

  // window: chain of cells, newest byte enters at the top
  genvar g;
  generate
    for (g = 0; g < WIN_DEPTH; g++) begin : g_cell
      if (g == WIN_DEPTH - 1) begin : g_top
        assign chain_in[g] = s_tdata;
      end else begin : g_mid
        assign chain_in[g] = win[g+1];
      end
      msbs_cell #(.IDX(g)) u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .din      (chain_in[g]),
        .dout     (win[g]),
        .hit      (hits[g])
      );
    end
  endgenerate
  assign hits[PATTERN_BYTES-1] = sig_hit(PATTERN_BYTES - 1, s_tdata);

  // match qualification; window contents count only after a full candidate
  assign seen_now = (bytes_seen == SEEN_MAX) ? bytes_seen : bytes_seen + SEEN_W'(1);
  assign in_range = (seen_now >= PAT_LEN) && (seen_now <= SEEN_LIMIT);
  assign hit      = !match_done && in_range && (&hits);
  assign emit     = accept && (hit || (s_tlast && !match_done));

  // resolved target: base + offset + 7 + sign-extended displacement
  assign offset = OFFSET_W'(seen_now - PAT_LEN);
  assign disp   = {win[6], win[5], win[4], win[3]};
  assign target = section_base + ADDR_W'(offset) + INSN_LEN
                + {{(ADDR_W-32){disp[31]}}, disp};

  always_comb begin
    result.found          = hit;
    result.match_offset   = hit ? offset : '0;
    result.target_address = hit ? target : '0;
  end

  // section state
  always_ff @(posedge clk) begin
    if (rst) begin
      section_base <= '0;
      bytes_seen   <= '0;
      match_done   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        section_base <= cfg_wr_data;
      end
      if (accept) begin
        if (s_tlast) begin
          bytes_seen <= '0;
          match_done <= 1'b0;
        end else begin
          bytes_seen <= seen_now;
          if (hit) begin
            match_done <= 1'b1;
          end
        end
      end
    end
  end

  msbs_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_data (result),
    .can_push  (can_push),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {1'b0, out_res};

endmodule

### bench/tb_top.sv
// Testbench for the masked byte signature scanner: random sections against a scoreboard.
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASE_ITEMS = 80;

  localparam logic [30:0] SEEN_TOP   = 31'h7FFF_FFFF;
  localparam logic [29:0] OFFSET_TOP = 30'h3FFF_FFFF;

  // signature bytes and care mask (bit j set: byte j must match exactly)
  localparam logic [7:0] PATTERN_VAL [28] = '{
    8'h48, 8'h89, 8'h05, 8'h00, 8'h00, 8'h00, 8'h00, 8'hE8, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h33, 8'hD2, 8'h41, 8'hB8, 8'hF8, 8'h0A, 8'h00, 8'h00,
    8'h48, 8'h8B, 8'hC8, 8'h48, 8'h8B, 8'hD8, 8'hE8, 8'h00
  };
  localparam logic [27:0] PATTERN_MASK = 28'b0111_1111_1111_1111_0000_1000_0111;

  // scanner model: tracks section state and the queue of results still owed
  class match_tracker;
    logic [7:0]  window [27];   // index 0 holds the oldest byte
    logic [30:0] seen;
    bit          matched;
    logic [47:0] base;
    msbs_pkg::msbs_result_t pending_results[$];
    int          errors;

    function new();
      base = '0;
      errors = 0;
      clear_section();
    endfunction

    function void clear_section();
      foreach (window[j]) window[j] = '0;
      seen = '0;
      matched = 0;
    endfunction

    // one accepted request: update state, queue any result it causes
    function void take_byte(logic [7:0] b, bit l);
      logic [7:0]  cand [28];
      logic [30:0] seen_now;
      logic [31:0] disp;
      logic [29:0] offs;
      bit hit;
      msbs_pkg::msbs_result_t r;
      for (int j = 0; j < 27; j++) cand[j] = window[j];
      cand[27] = b;
      seen_now = (seen == SEEN_TOP) ? seen : seen + 31'd1;
      if (!matched && seen_now >= 28 && (seen_now - 28) <= OFFSET_TOP) begin
        hit = 1;
        for (int j = 0; j < 28; j++)
          if (PATTERN_MASK[j] && cand[j] != PATTERN_VAL[j]) hit = 0;
        if (hit) begin
          offs = 30'(seen_now - 28);
          disp = {cand[6], cand[5], cand[4], cand[3]};
          r.found = 1'b1;
          r.match_offset = offs;
          r.target_address = base + 48'(offs) + 48'd7 + {{16{disp[31]}}, disp};
          pending_results.push_back(r);
          matched = 1;
        end
      end
      if (l) begin
        // not-found only when nothing was reported in this section
        if (!matched) begin
          r = '0;
          pending_results.push_back(r);
        end
        clear_section();
      end else begin
        for (int j = 0; j < 26; j++) window[j] = window[j+1];
        window[26] = b;
        seen = seen_now;
      end
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH: %s", what);
      errors++;
    endtask

    // one accepted result against the oldest expectation
    task check_result(logic [79:0] d);
      msbs_pkg::msbs_result_t e;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h with none pending", d));
        return;
      end
      e = pending_results.pop_front();
      if (d[0] !== e.found)
        report_mismatch($sformatf("found %b, want %b", d[0], e.found));
      if (d[30:1] !== e.match_offset)
        report_mismatch($sformatf("match_offset %0d, want %0d", d[30:1], e.match_offset));
      if (d[78:31] !== e.target_address)
        report_mismatch($sformatf("target_address %h, want %h", d[78:31],
                                  e.target_address));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [47:0] cfg_wr_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;     // [7:0] code_byte
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;          // [0] found, [30:1] match_offset, [78:31] target_address

  match_tracker tracker;
  logic [7:0] sec_bytes[$];
  logic [7:0] carry_bytes[$];
  int  src_idle_pct = 0;
  int  snk_idle_pct = 0;
  int  accepted = 0;
  int  cycle_count = 0;
  bit  hold_sink = 0;

  masked_byte_signature_scanner u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata);
  end

  // result side backpressure, with one long hold on demand
  initial begin
    forever begin
      @(negedge clk);
      if (hold_sink) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_sink = 0;
      end
      m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  task automatic write_base(input logic [47:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    tracker.base = v;
  endtask

  // one request; starts and ends at a falling edge
  task automatic send_byte(input logic [7:0] b, input bit l);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.take_byte(b, l);
    accepted++;
    @(negedge clk);
  endtask

  // send the built section, tlast on its final byte
  task automatic send_run();
    foreach (sec_bytes[i]) send_byte(sec_bytes[i], i == sec_bytes.size() - 1);
  endtask

  // stop sending, wait for all owed results, let the pipe go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_disp();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_noise(input int n);
    repeat (n) sec_bytes.push_back(8'($urandom));
  endtask

  // full signature with random wildcards; optionally one care byte spoiled
  task automatic push_signature(input bit spoil);
    logic [31:0] disp;
    logic [7:0] b;
    int bad;
    disp = pick_disp();
    bad = -1;
    if (spoil) begin
      do bad = $urandom_range(27); while (!PATTERN_MASK[bad]);
    end
    for (int j = 0; j < 28; j++) begin
      if (j >= 3 && j <= 6) b = disp[(j-3)*8 +: 8];
      else if (PATTERN_MASK[j]) b = PATTERN_VAL[j];
      else b = 8'($urandom);
      if (j == bad) b = b ^ (8'd1 << $urandom_range(7));
      sec_bytes.push_back(b);
    end
  endtask

  // one random section: mostly well formed, some broken, some noise
  task automatic send_section();
    int kind;
    int start;
    int k;
    sec_bytes = carry_bytes;
    carry_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 15) begin
      push_noise($urandom_range(1, 40));
    end else if (kind < 30) begin
      // signature cut by the section end; the rest may open the next section
      push_noise($urandom_range(0, 10));
      start = sec_bytes.size();
      push_signature(0);
      k = $urandom_range(1, 27);
      while (sec_bytes.size() > start + k) carry_bytes.push_front(sec_bytes.pop_back());
      if ($urandom_range(1)) carry_bytes.delete();
    end else begin
      push_noise(($urandom_range(9) == 0) ? $urandom_range(0, 200) : $urandom_range(0, 30));
      push_signature(kind < 50);
      if ($urandom_range(3) == 0) push_signature(0);
      if ($urandom_range(3) != 0) push_noise($urandom_range(1, 12));
    end
    send_run();
  endtask

  initial begin
    logic [47:0] base_val;
    int goal;
    tracker = new();
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: base_val = 48'hFFFF_FFFF_FFFF;
        1: base_val = 48'h0;
        3: base_val = 48'h8000_0000_0000;
        5: base_val = 48'hFFFF_FFFF_FFF0;
        default: base_val = 48'({$urandom, $urandom});
      endcase
      write_base(base_val);
      if (ph < 2) begin
        src_idle_pct = 38;
        snk_idle_pct = 62;
      end else if (ph < 4) begin
        src_idle_pct = 62;
        snk_idle_pct = 38;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end

      if (ph == 0) begin
        // one-byte sections at both byte extremes, then a match on the last byte
        sec_bytes = '{8'h00};
        send_run();
        sec_bytes = '{8'hFF};
        send_run();
        sec_bytes.delete();
        for (int j = 0; j < 28; j++)
          sec_bytes.push_back(PATTERN_MASK[j] ? PATTERN_VAL[j] : 8'hFF);
        sec_bytes[3] = 8'h00;
        sec_bytes[4] = 8'h00;
        sec_bytes[5] = 8'h00;
        sec_bytes[6] = 8'h80;
        send_run();
      end

      if (ph == 4) begin
        // long result-side hold while one-byte sections keep coming
        hold_sink = 1;
        repeat (12) begin
          sec_bytes = '{8'($urandom)};
          send_run();
        end
      end

      goal = accepted + PHASE_ITEMS;
      while (accepted < goal) send_section();
      settle();
    end

    repeat (10) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
